@@ hw/rtl/mubn_pkg.sv @@
// ----------------------------------------------------------------------------
// mubn_pkg
// Shared types and codes for the unit-box vertex normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package mubn_pkg;

  localparam int unsigned IdxBits = 10;
  localparam int unsigned OutBits = 16;
  localparam int unsigned FracBits = 14;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_DEGEN  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_FIXED = 2'd1,
    OP_SCALE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DIV,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/mubn_divider.sv @@
// ----------------------------------------------------------------------------
// mubn_divider
// Restoring divider, one quotient bit per cycle, signed result truncated
// toward zero. Dividend magnitude is below 2^(NB), divisor nonzero.
// ----------------------------------------------------------------------------
`default_nettype none
module mubn_divider #(
  parameter int unsigned NB = 32,
  parameter int unsigned DB = 18
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          neg,
  input  wire logic [NB-1:0] num_mag,
  input  wire logic [DB-1:0] den,
  output logic               done,
  output logic [NB:0]        quot
);
  localparam int unsigned CB = $clog2(NB + 1);

  logic [NB-1:0] q;
  logic [DB:0]   rem;
  logic [CB-1:0] cnt;
  logic          busy;
  logic          sgn;
  logic [DB:0]   trial;
  logic [DB:0]   shifted;

  always_comb begin
    shifted = {rem[DB-1:0], q[NB-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(NB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num_mag;
      rem <= '0;
      sgn <= neg;
    end else if (busy) begin
      if (!trial[DB]) begin
        rem <= trial;
        q   <= {q[NB-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[NB-2:0], 1'b0};
      end
    end
  end

  assign quot = sgn ? -{1'b0, q} : {1'b0, q};
endmodule
`default_nettype wire

@@ hw/rtl/mubn_front.sv @@
// ----------------------------------------------------------------------------
// mubn_front
// Takes load and read beats, owns the vertex count and bounding box, and
// pushes classified work into the queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module mubn_front #(
  parameter int unsigned MAX_VERTS  = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              req_type,
  input  wire logic                              new_mesh,
  input  wire logic [15:0]                       x_coord,
  input  wire logic [15:0]                       y_coord,
  input  wire logic [15:0]                       z_coord,
  input  wire logic [mubn_pkg::IdxBits-1:0]      vertex_index,
  output logic                                   wr_en,
  output logic [$clog2(MAX_VERTS)-1:0]           wr_addr,
  output logic [3*COORD_BITS-1:0]                wr_data,
  output logic                                   q_push,
  input  wire logic                              q_full,
  input  wire logic                              q_valid,
  output logic [1:0]                             q_op,
  output logic [1:0]                             q_status,
  output logic [mubn_pkg::IdxBits-1:0]           q_index,
  output logic [6*COORD_BITS-1:0]                q_bounds,
  output logic [COORD_BITS:0]                    q_ext
);
  import mubn_pkg::*;
  localparam int unsigned AB = $clog2(MAX_VERTS);
  localparam int unsigned CNTB = $clog2(MAX_VERTS + 1);
  localparam int unsigned W = COORD_BITS;
  localparam int unsigned KB = (CNTB > IdxBits) ? CNTB : IdxBits;

  logic [CNTB-1:0] count;
  logic signed [W-1:0] mn [3];
  logic signed [W-1:0] mx [3];
  logic signed [W-1:0] v [3];
  logic signed [W:0] ex [3];
  logic [CNTB-1:0] base;
  logic fire;
  logic full;
  logic restart_hold;
  logic [W:0] ext;

  assign v[0] = W'(x_coord);
  assign v[1] = W'(y_coord);
  assign v[2] = W'(z_coord);
  // hold a new-mesh load while queued reads may still fetch the old entries
  assign restart_hold = !req_type && new_mesh && q_valid;
  assign in_ready = !q_full && !restart_hold;
  assign fire = in_valid && in_ready;
  assign base = new_mesh ? '0 : count;
  assign full = (base >= CNTB'(MAX_VERTS));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = (W+1)'(mx[i]) - (W+1)'(mn[i]);
    end
    priority if (ex[0] >= ex[1] && ex[0] >= ex[2]) ext = ex[0];
    else if (ex[1] >= ex[2]) ext = ex[1];
    else ext = ex[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < 3; i++) begin
        mn[i] <= {1'b0, {(W-1){1'b1}}};
        mx[i] <= {1'b1, {(W-1){1'b0}}};
      end
    end else if (fire && !req_type) begin
      if (!full) begin
        count <= base + 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (new_mesh) begin
            mn[i] <= v[i];
            mx[i] <= v[i];
          end else begin
            if (v[i] < mn[i]) mn[i] <= v[i];
            if (v[i] > mx[i]) mx[i] <= v[i];
          end
        end
      end else if (new_mesh) begin
        count <= '0;
      end
    end
  end

  assign wr_en   = fire && !req_type && !full;
  assign wr_addr = AB'(base);
  assign wr_data = {v[2], v[1], v[0]};

  always_comb begin
    q_push   = 1'b0;
    q_op     = OP_FIXED;
    q_status = ST_OK;
    q_index  = vertex_index;
    if (fire) begin
      if (!req_type) begin
        q_push   = full;
        q_status = ST_RANGE;
        q_index  = '0;
      end else begin
        q_push = 1'b1;
        priority if (count == '0) q_status = ST_DEGEN;
        else if (KB'(vertex_index) >= KB'(count)) q_status = ST_RANGE;
        else if (ext == '0) q_status = ST_DEGEN;
        else q_op = OP_SCALE;
      end
    end
  end

  assign q_bounds = {mx[2], mx[1], mx[0], mn[2], mn[1], mn[0]};
  assign q_ext = ext;
endmodule
`default_nettype wire

@@ hw/rtl/mubn_back.sv @@
// ----------------------------------------------------------------------------
// mubn_back
// Pops queued work, reads the stored vertex, runs one shared divider over
// the three axes and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mubn_back #(
  parameter int unsigned MAX_VERTS  = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_VERTS)-1:0]  wr_addr,
  input  wire logic [3*COORD_BITS-1:0]       wr_data,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [1:0]                    q_op,
  input  wire logic [1:0]                    q_status,
  input  wire logic [mubn_pkg::IdxBits-1:0]  q_index,
  input  wire logic [6*COORD_BITS-1:0]       q_bounds,
  input  wire logic [COORD_BITS:0]           q_ext,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mubn_pkg::IdxBits-1:0]       out_index,
  output logic [3*mubn_pkg::OutBits-1:0]     out_norm,
  output logic [1:0]                         out_status
);
  import mubn_pkg::*;
  localparam int unsigned W = COORD_BITS;
  localparam int unsigned AB = $clog2(MAX_VERTS);
  localparam int unsigned NB = W + 2 + FracBits;

  logic [3*W-1:0] mem [MAX_VERTS];
  logic [3*W-1:0] rd_data;
  bk_state_t state, state_next;
  logic [1:0] axis;
  logic [6*W-1:0] bounds;
  logic [W:0] ext;
  logic [IdxBits-1:0] idx;
  logic [2*OutBits-1:0] acc;
  logic [OutBits-1:0] acc_z;
  logic out_free;
  logic div_start, div_done;
  logic signed [W+1:0] cen;
  logic [NB-1:0] mag;
  logic [NB:0] quot;
  logic signed [W-1:0] vv, lo, hi;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end
  // hold the popped vertex for all three axes
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_pop) rd_data <= mem[AB'(q_index)];
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (axis)
      2'd0: begin vv = rd_data[W-1:0];     lo = bounds[W-1:0];   hi = bounds[4*W-1:3*W]; end
      2'd1: begin vv = rd_data[2*W-1:W];   lo = bounds[2*W-1:W]; hi = bounds[5*W-1:4*W]; end
      default: begin
        vv = rd_data[3*W-1:2*W]; lo = bounds[3*W-1:2*W]; hi = bounds[6*W-1:5*W];
      end
    endcase
    cen = ((W+2)'(vv) <<< 1) - (W+2)'(lo) - (W+2)'(hi);
    mag = cen[W+1] ? NB'(-cen) << FracBits : NB'(cen) << FracBits;
  end

  mubn_divider #(.NB(NB), .DB(W + 1)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .neg(cen[W+1]),
    .num_mag(mag), .den(ext), .done(div_done), .quot(quot)
  );

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    div_start = 1'b0;
    unique case (state)
      BK_IDLE: if (q_valid && out_free) begin
        q_pop = 1'b1;
        if (q_op == OP_SCALE) state_next = BK_READ;
      end
      BK_READ: begin
        div_start = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: if (div_done) begin
        if (axis == 2'd2) state_next = BK_OUT;
        else state_next = BK_READ;
      end
      BK_OUT: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      axis <= '0;
    end else begin
      state <= state_next;
      if (state == BK_DIV && div_done) axis <= axis + 1'b1;
      else if (state == BK_IDLE && q_pop) axis <= '0;
      if ((state == BK_IDLE && q_pop && q_op != OP_SCALE) || (state == BK_OUT && out_free))
        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_pop) begin
      bounds <= q_bounds;
      ext <= q_ext;
      idx <= q_index;
      if (q_op != OP_SCALE) begin
        out_index <= q_index;
        out_norm <= '0;
        out_status <= q_status;
      end
    end
    if (state == BK_DIV && div_done && axis != 2'd2)
      acc <= {OutBits'(quot), acc[2*OutBits-1:OutBits]};
    if (state == BK_DIV && div_done && axis == 2'd2)
      acc <= {OutBits'(quot), acc[2*OutBits-1:OutBits]};
    if (state == BK_OUT && out_free) begin
      out_index <= idx;
      out_norm <= {acc[2*OutBits-1:OutBits], acc[OutBits-1:0], acc_z};
      out_status <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_DIV && div_done && axis == 2'd0) acc_z <= OutBits'(quot);
  end
endmodule
`default_nettype wire

@@ hw/rtl/mubn_queue.sv @@
// ----------------------------------------------------------------------------
// mubn_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module mubn_queue #(
  parameter int unsigned DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] din,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output logic [DW-1:0]      dout
);
  logic [DW-1:0] slot [2];
  logic rd, wr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign dout = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wr <= !wr;
      if (pop) rd <= !rd;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (push) slot[wr] <= din;
  end
endmodule
`default_nettype wire

@@ hw/rtl/mesh_unit_box_normalizer.sv @@
// ----------------------------------------------------------------------------
// mesh_unit_box_normalizer
// Stores vertices, tracks their bounding box and returns a vertex scaled
// into the unit cube on request.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low->high)                               tuser
//  s_axis   in   x,y,z,vertex_index (58 -> 64 bits)             req_type,new_mesh
//  m_axis   out  out_index,norm_x,norm_y,norm_z (58 -> 64 bits)  status
//
//  A load that fits is written straight into the vertex store. A read that
//  scales passes each axis in turn through the shared one-bit-per-cycle
//  divider (BK_READ, then BK_DIV) and leaves its result beat from BK_OUT.
//  Other reads and a load into a full store skip the divider and return as
//  the idle back end pops them. rst is synchronous; the vertex store needs none.
//  A stalled m_axis fills the queue, then drops s_axis_tready; a new-mesh load
//  also waits until the queue is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module mesh_unit_box_normalizer #(
  parameter int unsigned MAX_VERTS  = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // x_coord, y_coord, z_coord, vertex_index
  input  wire logic [1:0]  s_axis_tuser,  // req_type, new_mesh
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // out_index, norm_x, norm_y, norm_z
  output logic [1:0]       m_axis_tuser   // status
);
  import mubn_pkg::*;
  localparam int unsigned AB = $clog2(MAX_VERTS);
  localparam int unsigned W = COORD_BITS;
  localparam int unsigned QW = 4 + IdxBits + 6*W + W + 1;

  logic wr_en;
  logic [AB-1:0] wr_addr;
  logic [3*W-1:0] wr_data;
  logic q_push, q_full, q_pop, q_valid;
  logic [1:0] f_op, f_st, b_op, b_st;
  logic [IdxBits-1:0] f_idx, b_idx;
  logic [6*W-1:0] f_bd, b_bd;
  logic [W:0] f_ext, b_ext;
  logic [3*OutBits-1:0] norm;

  mubn_front #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tuser[0]), .new_mesh(s_axis_tuser[1]),
    .x_coord(s_axis_tdata[15:0]), .y_coord(s_axis_tdata[31:16]),
    .z_coord(s_axis_tdata[47:32]), .vertex_index(s_axis_tdata[57:48]),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .q_push(q_push), .q_full(q_full), .q_valid(q_valid), .q_op(f_op), .q_status(f_st),
    .q_index(f_idx), .q_bounds(f_bd), .q_ext(f_ext)
  );

  mubn_queue #(.DW(QW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din({f_op, f_st, f_idx, f_bd, f_ext}),
    .full(q_full), .pop(q_pop), .valid(q_valid),
    .dout({b_op, b_st, b_idx, b_bd, b_ext})
  );

  mubn_back #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(b_op), .q_status(b_st),
    .q_index(b_idx), .q_bounds(b_bd), .q_ext(b_ext),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_index(m_axis_tdata[9:0]), .out_norm(norm), .out_status(m_axis_tuser)
  );

  assign m_axis_tdata[57:10] = norm;
  assign m_axis_tdata[63:58] = '0;
endmodule
`default_nettype wire

@@ hw/rtl/mubn_checker.sv @@
// ----------------------------------------------------------------------------
// mubn_checker
// Port-level checks for the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mubn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import mubn_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[57:10] == '0)
    else $error("nonzero norm on error status");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != ST_UNUSED)
    else $error("bad status");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:58] == '0)
    else $error("pad bits set");
endmodule

bind mesh_unit_box_normalizer mubn_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

@@ tb/sv/mubn_checker.sv @@
// ----------------------------------------------------------------------------
// mubn_scoreboard
// Watches both streams of the unit-box normalizer, keeps its own copy of the
// vertex set and bounding box, predicts every returned vertex and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module mubn_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  output int               fail_count,
  output int               pending,
  output int               result_count
);
  import mubn_pkg::*;

  localparam int NVerts = 1024;
  localparam logic signed [15:0] CoordTop = 16'sh7fff;
  localparam logic signed [15:0] CoordBot = -16'sh8000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
    logic [9:0]  idx;
  } vout_t;

  logic signed [15:0] px [NVerts], py [NVerts], pz [NVerts];
  int                 vcount;
  logic signed [15:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  vout_t              expected_q [$];

  function automatic logic [15:0] unit_scale(longint v, longint lo, longint hi, longint ext);
    longint num;
    num = (2 * v - lo - hi) * 16384;
    return 16'(num / ext);
  endfunction

  task automatic predict_vertex(input logic [63:0] d, input logic [1:0] u);
    vout_t  r;
    longint ex, ey, ez, ext;
    logic signed [15:0] x, y, z;
    logic [9:0] idx;
    x = d[15:0]; y = d[31:16]; z = d[47:32]; idx = d[57:48];
    r = '0;
    if (!u[0]) begin
      if (u[1]) begin
        vcount = 0;
        lo_x = CoordTop; lo_y = CoordTop; lo_z = CoordTop;
        hi_x = CoordBot; hi_y = CoordBot; hi_z = CoordBot;
      end
      if (vcount >= NVerts) begin
        r.status = ST_RANGE;
        expected_q.push_back(r);
      end else begin
        px[vcount] = x; py[vcount] = y; pz[vcount] = z;
        vcount++;
        if (x < lo_x) lo_x = x;
        if (y < lo_y) lo_y = y;
        if (z < lo_z) lo_z = z;
        if (x > hi_x) hi_x = x;
        if (y > hi_y) hi_y = y;
        if (z > hi_z) hi_z = z;
      end
      return;
    end
    r.idx = idx;
    if (vcount == 0) r.status = ST_DEGEN;
    else if (idx >= vcount) r.status = ST_RANGE;
    else begin
      ex = longint'(hi_x) - lo_x; ey = longint'(hi_y) - lo_y; ez = longint'(hi_z) - lo_z;
      if (ex >= ey && ex >= ez) ext = ex;
      else if (ey >= ez) ext = ey;
      else ext = ez;
      if (ext <= 0) r.status = ST_DEGEN;
      else begin
        r.status = ST_OK;
        r.nx = unit_scale(px[idx], lo_x, hi_x, ext);
        r.ny = unit_scale(py[idx], lo_y, hi_y, ext);
        r.nz = unit_scale(pz[idx], lo_z, hi_z, ext);
      end
    end
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    vout_t got, want;
    if (rst) begin
      vcount = 0;
      lo_x = CoordTop; lo_y = CoordTop; lo_z = CoordTop;
      hi_x = CoordBot; hi_y = CoordBot; hi_z = CoordBot;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.idx = m_axis_tdata[9:0];
        got.nx = m_axis_tdata[25:10];
        got.ny = m_axis_tdata[41:26];
        got.nz = m_axis_tdata[57:42];
        got.status = m_axis_tuser;
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_vertex(s_axis_tdata, s_axis_tuser);
    end
    pending <= expected_q.size();
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives vertex loads and normalized reads into the unit-box normalizer with
// random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count, pending, result_count;
  int          hold_cycles = 0;
  int          mesh_size = 0;
  int          beat_count = 0;

  localparam int ReqLoad = 0;
  localparam int ReqRead = 1;

  always #5 clk = ~clk;

  mesh_unit_box_normalizer dut (.*);

  mubn_scoreboard u_checker (.*);

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] rand_coord(int spread);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  // valid stays up after a beat so a zero gap gives back-to-back beats
  task automatic send_beat(input int req, input bit fresh, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z, input int idx);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, 10'(idx), z, y, x};
    s_axis_tuser  <= {fresh, 1'(req)};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beat_count++;
    if (req == ReqLoad) mesh_size = fresh ? 1 : ((mesh_size < 1024) ? mesh_size + 1 : 1024);
  endtask

  task automatic send_read(input int idx);
    send_beat(ReqRead, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom), idx);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // receiver: random stalls, plus long hold-offs requested by the sender
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 3) == 0) m_axis_tready <= ($urandom_range(0, 9) == 0);
    else m_axis_tready <= 1'b1;
  end

  initial begin
    int sz;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty mesh, then a single point (zero extent)
    send_read(0);
    send_read(1023);
    send_beat(ReqLoad, 1'b1, 16'h0005, 16'h0005, 16'h0005, 0);
    send_read(0);
    send_read(1);
    // extremes; ties between axes
    send_beat(ReqLoad, 1'b1, 16'h8000, 16'h8000, 16'h8000, 0);
    send_beat(ReqLoad, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 1023);
    send_beat(ReqLoad, 1'b0, 16'h0000, 16'hffff, 16'h0001, 0);
    for (int i = 0; i < 4; i++) send_read(i);
    send_beat(ReqLoad, 1'b1, 16'd0, 16'd0, 16'd0, 0);
    send_beat(ReqLoad, 1'b0, 16'd3, 16'd3, 16'd1, 0);
    send_beat(ReqLoad, 1'b0, 16'd1, 16'd2, 16'd3, 0);
    for (int i = 0; i < 3; i++) send_read(i);
    drain();
    // fill the store to capacity, then overflow it
    send_beat(ReqLoad, 1'b1, rand_coord(40), rand_coord(40), rand_coord(40), 0);
    while (mesh_size < 1024) send_beat(ReqLoad, 1'b0, rand_coord(40), rand_coord(40),
                                       rand_coord(40), $urandom);
    send_beat(ReqLoad, 1'b0, 16'h7fff, 16'h8000, 16'h1234, 0);
    send_read(1023);
    send_read(0);
    // long receiver hold-off while reads keep coming
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_read($urandom_range(0, 1023));
    drain();
    // random meshes: mostly small well-formed ones, reads mostly in range
    while (beat_count < 1600) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
      for (int i = 0; i < sz; i++)
        send_beat(ReqLoad, i == 0, rand_coord(1 << $urandom_range(1, 15)),
                  rand_coord(1 << $urandom_range(1, 15)),
                  rand_coord(1 << $urandom_range(1, 15)), $urandom);
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 7) == 0) send_read($urandom_range(0, 1023));
        else send_read($urandom_range(0, mesh_size - 1));
      end
    end
    drain();
    $display("covered empty, single-point, full-store and extreme meshes plus random ones;");
    $display("%0d results checked", result_count);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #200000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/mubn_pkg.sv
hw/rtl/mubn_divider.sv
hw/rtl/mubn_front.sv
hw/rtl/mubn_back.sv
hw/rtl/mubn_queue.sv
hw/rtl/mesh_unit_box_normalizer.sv
hw/rtl/mubn_checker.sv
tb/sv/mubn_checker.sv
tb/sv/tb_top.sv
